>>> design/dgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagonal gradient stripe pixel package
// Shared widths, colour stop tables and register addresses for the pixel unit.
// ----------------------------------------------------------------------------
package dgs_pkg;

   // pipeline shape
   localparam int NUM_STAGES   = 11;
   localparam int POS_STAGES   = 4;
   localparam int GRAD_STAGES  = 5;
   localparam int BLEND_STAGES = 2;

   // field widths
   localparam int COORD_W   = 10;
   localparam int COLOUR_W  = 8;
   localparam int HALF_W_W  = 5;
   localparam int OPACITY_W = 9;

   // coordinate arithmetic
   localparam int FRAC_W    = 16;
   localparam int NUM_W     = COORD_W + FRAC_W;   // x * 2^16, also reciprocal width
   localparam int PX_W      = NUM_W + COORD_W;    // x * reciprocal
   localparam int SUM_W     = COORD_W + 1;
   localparam int PU_W      = SUM_W + FRAC_W;     // (x + y) * 1/sqrt2 in Q16
   localparam int UH_W      = SUM_W;              // whole rotated pixels
   localparam int UL_W      = 8;                  // Q11.8 fraction
   localparam int RECIP_P_W = 22;
   localparam int PQ_W      = UH_W + RECIP_P_W;
   localparam int T_W       = NUM_W;
   localparam int M_W       = 16;

   localparam logic [FRAC_W-1:0] INV_SQRT2 = 16'd46341;

   // gradient arithmetic
   localparam int DIFF_W  = 15;
   localparam int RECIP_W = 19;
   localparam int SEGP_W  = DIFF_W + RECIP_W;
   localparam int SEG_W   = 17;
   localparam logic [SEG_W-1:0] SEG_ONE = 17'd65536;
   localparam logic [SEG_W-1:0] STOP_1  = 17'd29491;
   localparam logic [SEG_W-1:0] STOP_2  = 17'd49152;
   localparam int MIX_W   = 27;

   typedef logic [1:0] seg_idx_type;
   localparam seg_idx_type SEG_LOW  = 2'd0;
   localparam seg_idx_type SEG_MID  = 2'd1;
   localparam seg_idx_type SEG_HIGH = 2'd2;

   typedef logic [COLOUR_W-1:0]  colour_type;
   typedef colour_type [0:2]     rgb_type;
   typedef logic signed [8:0]    delta_type;
   typedef delta_type [0:2]      delta_rgb_type;

   // configuration registers
   localparam logic CSR_HALF_WIDTH = 1'b0;
   localparam logic CSR_OPACITY    = 1'b1;
   localparam logic [HALF_W_W-1:0]  HALF_WIDTH_RESET = 5'd10;
   localparam logic [OPACITY_W-1:0] OPACITY_RESET    = 9'd115;
   localparam logic [OPACITY_W-1:0] OPACITY_FULL     = 9'd256;

   function automatic logic [SEG_W-1:0] seg_start(input seg_idx_type s);
      logic [SEG_W-1:0] v;
      case (s)
         SEG_LOW:  v = 17'd0;
         SEG_MID:  v = STOP_1;
         SEG_HIGH: v = STOP_2;
         default:  v = STOP_2;
      endcase
      return v;
   endfunction

   function automatic logic [DIFF_W-1:0] seg_len(input seg_idx_type s);
      logic [DIFF_W-1:0] v;
      case (s)
         SEG_LOW:  v = 15'd29491;
         SEG_MID:  v = 15'd19661;
         SEG_HIGH: v = 15'd16384;
         default:  v = 15'd16384;
      endcase
      return v;
   endfunction

   // round(2^32 / segment length)
   function automatic logic [RECIP_W-1:0] seg_recip(input seg_idx_type s);
      logic [RECIP_W-1:0] v;
      case (s)
         SEG_LOW:  v = 19'd145637;
         SEG_MID:  v = 19'd218451;
         SEG_HIGH: v = 19'd262144;
         default:  v = 19'd262144;
      endcase
      return v;
   endfunction

   // colour at the start of a segment
   function automatic rgb_type seg_base(input seg_idx_type s);
      rgb_type c;
      case (s)
         SEG_LOW:  c = {8'd244, 8'd114, 8'd182};
         SEG_MID:  c = {8'd251, 8'd113, 8'd133};
         SEG_HIGH: c = {8'd249, 8'd115, 8'd22};
         default:  c = {8'd249, 8'd115, 8'd22};
      endcase
      return c;
   endfunction

   // end colour minus start colour of a segment
   function automatic delta_rgb_type seg_delta(input seg_idx_type s);
      delta_rgb_type d;
      case (s)
         SEG_LOW:  d = {9'sd7, -9'sd1, -9'sd49};
         SEG_MID:  d = {-9'sd2, 9'sd2, -9'sd111};
         SEG_HIGH: d = {-9'sd15, -9'sd27, -9'sd10};
         default:  d = {-9'sd15, -9'sd27, -9'sd10};
      endcase
      return d;
   endfunction

endpackage

>>> design/dgs_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagonal position stages
// Four stages: gradient position t in Q0.16 and the rotated coordinate taken
// modulo the stripe period, both through reciprocal multiplies with one
// correction step.
// ----------------------------------------------------------------------------
module dgs_pos import dgs_pkg::*; #(
   parameter int FRAME_WIDTH   = 800,
   parameter int FRAME_HEIGHT  = 800,
   parameter int STRIPE_PERIOD = 60
) (
   input  logic                  clock,
   input  logic [POS_STAGES-1:0] stage_en,
   input  logic [COORD_W-1:0]    pixel_x,
   input  logic [COORD_W-1:0]    pixel_y,
   output logic [T_W-1:0]        pos_t,
   output logic [M_W-1:0]        pos_m
);

   localparam logic [NUM_W-1:0]     RECIP_X = NUM_W'((64'd1 << NUM_W) / FRAME_WIDTH);
   localparam logic [NUM_W-1:0]     RECIP_Y = NUM_W'((64'd1 << NUM_W) / FRAME_HEIGHT);
   localparam logic [RECIP_P_W-1:0] RECIP_P =
      RECIP_P_W'((64'd1 << RECIP_P_W) / STRIPE_PERIOD);
   localparam logic [NUM_W:0] WIDTH_C  = (NUM_W + 1)'(FRAME_WIDTH);
   localparam logic [NUM_W:0] HEIGHT_C = (NUM_W + 1)'(FRAME_HEIGHT);
   localparam logic [UH_W-1:0] PERIOD_C = UH_W'(STRIPE_PERIOD);

   // stage 1
   logic [SUM_W-1:0]   sum_xy;
   logic [PU_W-1:0]    pu;
   logic [PX_W-1:0]    px1_in, py1_in, px1_ff, py1_ff;
   logic [COORD_W-1:0] x1_ff, y1_ff;
   logic [UH_W-1:0]    uh1_ff;
   logic [UL_W-1:0]    ul1_ff;

   // stage 2
   logic [NUM_W:0]     qxw2_in, qyw2_in, qxw2_ff, qyw2_ff;
   logic [NUM_W-1:0]   qx2_ff, qy2_ff;
   logic [COORD_W-1:0] x2_ff, y2_ff;
   logic [PQ_W-1:0]    pq2_in, pq2_ff;
   logic [UH_W-1:0]    uh2_ff;
   logic [UL_W-1:0]    ul2_ff;

   // stage 3
   logic [NUM_W:0]     rx, ry;
   logic [NUM_W-1:0]   tx3_in, ty3_in, tx3_ff, ty3_ff;
   logic [UH_W-1:0]    qpp3_in, qpp3_ff, uh3_ff;
   logic [UL_W-1:0]    ul3_ff;

   // stage 4
   logic [NUM_W:0]     t_sum;
   logic [UH_W-1:0]    rp, rem;
   logic [T_W-1:0]     t4_in, t4_ff;
   logic [M_W-1:0]     m4_in, m4_ff;

   assign sum_xy = {1'b0, pixel_x} + {1'b0, pixel_y};
   assign pu     = {{(PU_W-SUM_W){1'b0}}, sum_xy} * {{(PU_W-FRAC_W){1'b0}}, INV_SQRT2};
   assign px1_in = {{NUM_W{1'b0}}, pixel_x} * {{COORD_W{1'b0}}, RECIP_X};
   assign py1_in = {{NUM_W{1'b0}}, pixel_y} * {{COORD_W{1'b0}}, RECIP_Y};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         px1_ff <= px1_in;
         py1_ff <= py1_in;
         x1_ff  <= pixel_x;
         y1_ff  <= pixel_y;
         uh1_ff <= pu[PU_W-1:FRAC_W];
         ul1_ff <= pu[FRAC_W-1:FRAC_W-UL_W];
      end
   end

   // estimated quotient times divisor, kept modulo 2^27
   assign qxw2_in = {1'b0, px1_ff[PX_W-1:COORD_W]} * WIDTH_C;
   assign qyw2_in = {1'b0, py1_ff[PX_W-1:COORD_W]} * HEIGHT_C;
   assign pq2_in  = {{RECIP_P_W{1'b0}}, uh1_ff} * {{UH_W{1'b0}}, RECIP_P};

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         qx2_ff  <= px1_ff[PX_W-1:COORD_W];
         qy2_ff  <= py1_ff[PX_W-1:COORD_W];
         qxw2_ff <= qxw2_in;
         qyw2_ff <= qyw2_in;
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
         pq2_ff  <= pq2_in;
         uh2_ff  <= uh1_ff;
         ul2_ff  <= ul1_ff;
      end
   end

   // estimate is at most one short: remainder below twice the divisor
   assign rx      = {1'b0, x2_ff, {FRAC_W{1'b0}}} - qxw2_ff;
   assign ry      = {1'b0, y2_ff, {FRAC_W{1'b0}}} - qyw2_ff;
   assign tx3_in = qx2_ff + NUM_W'(rx >= WIDTH_C);
   assign ty3_in = qy2_ff + NUM_W'(ry >= HEIGHT_C);
   assign qpp3_in = pq2_ff[PQ_W-1:RECIP_P_W] * PERIOD_C;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         tx3_ff  <= tx3_in;
         ty3_ff  <= ty3_in;
         qpp3_ff <= qpp3_in;
         uh3_ff  <= uh2_ff;
         ul3_ff  <= ul2_ff;
      end
   end

   assign t_sum = {1'b0, tx3_ff} + {1'b0, ty3_ff};
   assign t4_in = t_sum[NUM_W:1];
   assign rp    = uh3_ff - qpp3_ff;
   assign rem   = (rp >= PERIOD_C) ? (rp - PERIOD_C) : rp;
   assign m4_in = {rem[UL_W-1:0], ul3_ff};

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         t4_ff <= t4_in;
         m4_ff <= m4_in;
      end
   end

   assign pos_t = t4_ff;
   assign pos_m = m4_ff;

endmodule

>>> design/dgs_grad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient and stripe stages
// Five stages: segment choice, segment fraction, colour interpolation across
// the stops, and the stripe test on the wrapped rotated coordinate.
// ----------------------------------------------------------------------------
module dgs_grad import dgs_pkg::*; #(
   parameter int STRIPE_PERIOD = 60
) (
   input  logic                   clock,
   input  logic [GRAD_STAGES-1:0] stage_en,
   input  logic [T_W-1:0]         pos_t,
   input  logic [M_W-1:0]         pos_m,
   input  logic [HALF_W_W-1:0]    half_width,
   output rgb_type                base_colour,
   output logic                   base_stripe
);

   localparam logic [M_W:0] SPAN_C = (M_W + 1)'(STRIPE_PERIOD * 256);

   // stage 5
   seg_idx_type         i5_in, i5_ff;
   logic [T_W-1:0]      diff;
   logic                full5_in, full5_ff;
   logic [DIFF_W-1:0]   diff5_ff;
   logic [M_W-1:0]      m5_ff;

   // stage 6
   logic [SEGP_W-1:0]   segp6_in, segp6_ff;
   seg_idx_type         i6_ff;
   logic                full6_ff;
   logic [M_W:0]        span_h;
   logic                stripe6_in, stripe6_ff;

   // stage 7
   logic [SEG_W:0]      segw;
   logic [SEG_W-1:0]    seg7_in, seg7_ff;
   seg_idx_type         i7_ff;
   logic                stripe7_ff;

   // stage 8
   delta_rgb_type       delta;
   logic signed [MIX_W-1:0] mixp8_in [3];
   logic signed [MIX_W-1:0] mixp8_ff [3];
   seg_idx_type         i8_ff;
   logic                stripe8_ff;

   // stage 9
   rgb_type             base;
   logic signed [SUM_W:0] ch_sum [3];
   rgb_type             ch9_in, ch9_ff;
   logic                stripe9_ff;

   always_comb begin
      if (pos_t <= T_W'(STOP_1)) begin
         i5_in = SEG_LOW;
      end else if (pos_t <= T_W'(STOP_2)) begin
         i5_in = SEG_MID;
      end else begin
         i5_in = SEG_HIGH;
      end
      diff     = pos_t - T_W'(seg_start(i5_in));
      full5_in = diff >= T_W'(seg_len(i5_in));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         i5_ff    <= i5_in;
         full5_ff <= full5_in;
         diff5_ff <= diff[DIFF_W-1:0];
         m5_ff    <= pos_m;
      end
   end

   assign segp6_in = {{RECIP_W{1'b0}}, diff5_ff} * {{DIFF_W{1'b0}}, seg_recip(i5_ff)};
   assign span_h   = {1'b0, m5_ff} + (M_W + 1)'({half_width, 8'd0});
   assign stripe6_in = (m5_ff < M_W'({half_width, 8'd0})) || (span_h > SPAN_C);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         segp6_ff   <= segp6_in;
         i6_ff      <= i5_ff;
         full6_ff   <= full5_ff;
         stripe6_ff <= stripe6_in;
      end
   end

   // saturate the fraction at one
   assign segw    = segp6_ff[SEGP_W-1:FRAC_W];
   assign seg7_in = (full6_ff || (segw > (SEG_W + 1)'(SEG_ONE))) ? SEG_ONE : segw[SEG_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         seg7_ff    <= seg7_in;
         i7_ff      <= i6_ff;
         stripe7_ff <= stripe6_ff;
      end
   end

   assign delta = seg_delta(i7_ff);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mixp8_in[k] = MIX_W'($signed(delta[k]) * $signed({1'b0, seg7_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         for (int k = 0; k < 3; k++) begin
            mixp8_ff[k] <= mixp8_in[k];
         end
         i8_ff      <= i7_ff;
         stripe8_ff <= stripe7_ff;
      end
   end

   // start colour plus floor of the scaled step
   assign base = seg_base(i8_ff);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ch_sum[k] = $signed({4'd0, base[k]}) + $signed(mixp8_ff[k][MIX_W-1:FRAC_W]);
         ch9_in[k] = ch_sum[k][COLOUR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         ch9_ff     <= ch9_in;
         stripe9_ff <= stripe8_ff;
      end
   end

   assign base_colour = ch9_ff;
   assign base_stripe = stripe9_ff;

endmodule

>>> design/dgs_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// White blend stages
// Two stages: scale the distance to white by the opacity, then add it for
// stripe pixels. The second stage is the output register.
// ----------------------------------------------------------------------------
module dgs_blend import dgs_pkg::*; (
   input  logic                    clock,
   input  logic [BLEND_STAGES-1:0] stage_en,
   input  rgb_type                 base_colour,
   input  logic                    base_stripe,
   input  logic [OPACITY_W-1:0]    opacity,
   output rgb_type                 pixel_colour,
   output logic                    pixel_stripe
);

   localparam int WP_W = COLOUR_W + OPACITY_W;

   logic [WP_W-1:0]     wp10_in [3];
   logic [WP_W-1:0]     wp10_ff [3];
   rgb_type             ch10_ff;
   logic                stripe10_ff;
   logic [COLOUR_W:0]   lift [3];
   rgb_type             out11_in, out11_ff;
   logic                stripe11_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wp10_in[k] = {{OPACITY_W{1'b0}}, 8'd255 - base_colour[k]}
                      * {{COLOUR_W{1'b0}}, opacity};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int k = 0; k < 3; k++) begin
            wp10_ff[k] <= wp10_in[k];
         end
         ch10_ff     <= base_colour;
         stripe10_ff <= base_stripe;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lift[k]     = {1'b0, ch10_ff[k]} + wp10_ff[k][WP_W-1:COLOUR_W];
         out11_in[k] = stripe10_ff ? lift[k][COLOUR_W-1:0] : ch10_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         out11_ff    <= out11_in;
         stripe11_ff <= stripe10_ff;
      end
   end

   assign pixel_colour = out11_ff;
   assign pixel_stripe = stripe11_ff;

endmodule

>>> design/diagonal_gradient_stripe_pixel_unit.sv
// An accepted coordinate runs through the pos, grad and blend stages to rsp_.
// Throughput: one pixel per cycle; each stage holds only when the stage after it
// is full and stalled, so bubbles close up and a waiting result does not block
// input while earlier stages have room.
// Reset clears every stage valid bit and sets half width 10 and opacity 115.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagonal gradient stripe pixel unit
// Test-pattern generator: coordinate in, gradient colour with white diagonal
// stripes out. Holds the configuration registers and the stage handshake.
// ----------------------------------------------------------------------------
module diagonal_gradient_stripe_pixel_unit import dgs_pkg::*; #(
   parameter int FRAME_WIDTH   = 800,
   parameter int FRAME_HEIGHT  = 800,
   parameter int STRIPE_PERIOD = 60
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COORD_W-1:0]   req_pixel_x,
   input  logic [COORD_W-1:0]   req_pixel_y,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COLOUR_W-1:0]  rsp_red,
   output logic [COLOUR_W-1:0]  rsp_green,
   output logic [COLOUR_W-1:0]  rsp_blue,
   output logic                 rsp_in_stripe,

   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   logic [NUM_STAGES-1:0] valid_in, valid_ff;
   logic [NUM_STAGES-1:0] stage_en;

   logic [HALF_W_W-1:0]  half_width_in, half_width_ff;
   logic [OPACITY_W-1:0] opacity_in, opacity_ff;
   logic [OPACITY_W-1:0] opacity_sat;
   logic                 csr_write;

   logic [T_W-1:0]       pos_t;
   logic [M_W-1:0]       pos_m;
   rgb_type              base_colour;
   logic                 base_stripe;
   rgb_type              pixel_colour;

   // a stage moves when empty or when the next one moves
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // configuration
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      half_width_in = half_width_ff;
      opacity_in    = opacity_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_HALF_WIDTH: half_width_in = pwdata[HALF_W_W-1:0];
            CSR_OPACITY:    opacity_in    = pwdata[OPACITY_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HALF_WIDTH_RESET;
         opacity_ff    <= OPACITY_RESET;
      end else begin
         half_width_ff <= half_width_in;
         opacity_ff    <= opacity_in;
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_HALF_WIDTH: prdata = {{(32-HALF_W_W){1'b0}}, half_width_ff};
         CSR_OPACITY:    prdata = {{(32-OPACITY_W){1'b0}}, opacity_ff};
         default:        prdata = '0;
      endcase
   end

   // anything past one is full white
   assign opacity_sat = (opacity_ff > OPACITY_FULL) ? OPACITY_FULL : opacity_ff;

   dgs_pos #(
      .FRAME_WIDTH   (FRAME_WIDTH),
      .FRAME_HEIGHT  (FRAME_HEIGHT),
      .STRIPE_PERIOD (STRIPE_PERIOD)
   ) u_pos (
      .clock    (clock),
      .stage_en (stage_en[POS_STAGES-1:0]),
      .pixel_x  (req_pixel_x),
      .pixel_y  (req_pixel_y),
      .pos_t    (pos_t),
      .pos_m    (pos_m)
   );

   dgs_grad #(
      .STRIPE_PERIOD (STRIPE_PERIOD)
   ) u_grad (
      .clock       (clock),
      .stage_en    (stage_en[POS_STAGES+GRAD_STAGES-1:POS_STAGES]),
      .pos_t       (pos_t),
      .pos_m       (pos_m),
      .half_width  (half_width_ff),
      .base_colour (base_colour),
      .base_stripe (base_stripe)
   );

   dgs_blend u_blend (
      .clock        (clock),
      .stage_en     (stage_en[NUM_STAGES-1:POS_STAGES+GRAD_STAGES]),
      .base_colour  (base_colour),
      .base_stripe  (base_stripe),
      .opacity      (opacity_sat),
      .pixel_colour (pixel_colour),
      .pixel_stripe (rsp_in_stripe)
   );

   assign rsp_red   = pixel_colour[0];
   assign rsp_green = pixel_colour[1];
   assign rsp_blue  = pixel_colour[2];

endmodule
